### design/measurement_register_extend_defines.svh
// Assertion macros shared by the design files.
`ifndef MEASUREMENT_REGISTER_EXTEND_DEFINES_SVH
`define MEASUREMENT_REGISTER_EXTEND_DEFINES_SVH

// Whenever a is true, b holds in the same cycle.
`define MRE_ASSERT_SAME(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// Whenever a is true, b holds in the next cycle.
`define MRE_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

### design/mre_pkg.sv
`timescale 1ns / 1ps
package mre_pkg;

	localparam int NUM_REGS = 4;
	localparam int SEL_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int LEN_W = 7;
	localparam logic [LEN_W-1:0] DIGEST_BYTES = 7'd48;
	localparam int ROUNDS = 80;
	localparam int RND_W = 7;

	// Status codes.
	localparam logic ST_EXTENDED = 1'b0;
	localparam logic ST_SKIPPED = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ROUND,
		S_FINISH,
		S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic round;
		logic finish;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic do_hash;
		logic last_round;
	} ctrl_sts_t;

	localparam logic [63:0] INIT_H [8] = '{
		64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
		64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
		64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
	};

	localparam logic [63:0] ROUND_K [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

endpackage

### design/measurement_register_extend.sv
`timescale 1ns / 1ps
// Channel  Handshake           Payload
// input    in_valid/in_ready   target_index, digest_len, digest_w0..digest_w5
// output   out_valid/out_ready status, out_index, value_w0..value_w5
//
// An extended item goes through one load, 80 rounds of the single SHA-384 round unit
// and one final add. A skipped item goes from the load straight to the result.
// One item is in flight at a time; the next is accepted after the result is taken.
// Reset (arst_n low) clears all four measurement registers to zero.
// A stalled output holds its result and blocks new input.
module measurement_register_extend (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  target_index,
	input  logic [6:0]  digest_len,
	input  logic [63:0] digest_w0,
	input  logic [63:0] digest_w1,
	input  logic [63:0] digest_w2,
	input  logic [63:0] digest_w3,
	input  logic [63:0] digest_w4,
	input  logic [63:0] digest_w5,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [3:0]  out_index,
	output logic [63:0] value_w0,
	output logic [63:0] value_w1,
	output logic [63:0] value_w2,
	output logic [63:0] value_w3,
	output logic [63:0] value_w4,
	output logic [63:0] value_w5
);

	mre_pkg::ctrl_cmd_t cmd;
	mre_pkg::ctrl_sts_t sts;

	// Sequencer.
	mre_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	// Hash datapath and register bank.
	mre_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.target_index(target_index), .digest_len(digest_len),
		.digest_w0(digest_w0), .digest_w1(digest_w1), .digest_w2(digest_w2),
		.digest_w3(digest_w3), .digest_w4(digest_w4), .digest_w5(digest_w5),
		.status(status), .out_index(out_index),
		.value_w0(value_w0), .value_w1(value_w1), .value_w2(value_w2),
		.value_w3(value_w3), .value_w4(value_w4), .value_w5(value_w5)
	);

endmodule

### design/mre_ctrl.sv
`timescale 1ns / 1ps
`include "measurement_register_extend_defines.svh"
module mre_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  mre_pkg::ctrl_sts_t  sts,
	output mre_pkg::ctrl_cmd_t  cmd
);

	mre_pkg::state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mre_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mre_pkg::S_IDLE: begin
				if (in_valid) state_d = mre_pkg::S_ROUND;
			end
			mre_pkg::S_ROUND: begin
				if (!sts.do_hash) state_d = mre_pkg::S_OUT;
				else if (sts.last_round) state_d = mre_pkg::S_FINISH;
			end
			mre_pkg::S_FINISH: state_d = mre_pkg::S_OUT;
			mre_pkg::S_OUT: begin
				if (out_ready) state_d = mre_pkg::S_IDLE;
			end
			default: state_d = mre_pkg::S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready = (state_q == mre_pkg::S_IDLE);
		out_valid = (state_q == mre_pkg::S_OUT);
		cmd.load = in_ready && in_valid;
		cmd.round = (state_q == mre_pkg::S_ROUND) && sts.do_hash;
		cmd.finish = (state_q == mre_pkg::S_FINISH);
	end

	`MRE_ASSERT_SAME(a_excl, clk, arst_n, out_valid, !in_ready)
	`MRE_ASSERT_NEXT(a_fin, clk, arst_n, cmd.finish, out_valid)
	`MRE_ASSERT_NEXT(a_load, clk, arst_n, cmd.load, state_q == mre_pkg::S_ROUND)

endmodule

### design/mre_dp.sv
`timescale 1ns / 1ps
`include "measurement_register_extend_defines.svh"
module mre_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  mre_pkg::ctrl_cmd_t  cmd,
	output mre_pkg::ctrl_sts_t  sts,
	input  logic [3:0]          target_index,
	input  logic [6:0]          digest_len,
	input  logic [63:0]         digest_w0,
	input  logic [63:0]         digest_w1,
	input  logic [63:0]         digest_w2,
	input  logic [63:0]         digest_w3,
	input  logic [63:0]         digest_w4,
	input  logic [63:0]         digest_w5,
	output logic                status,
	output logic [3:0]          out_index,
	output logic [63:0]         value_w0,
	output logic [63:0]         value_w1,
	output logic [63:0]         value_w2,
	output logic [63:0]         value_w3,
	output logic [63:0]         value_w4,
	output logic [63:0]         value_w5
);

	logic [383:0] bank_q [mre_pkg::NUM_REGS];
	logic [63:0] w_q [16];
	logic [63:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [mre_pkg::RND_W-1:0] rnd_q;
	logic [3:0] idx_q;
	logic [mre_pkg::SEL_W-1:0] sel_q;
	logic inrange_q, hash_q;
	logic [383:0] old_val;
	logic [mre_pkg::SEL_W-1:0] sel_in;
	logic inrange_in;
	logic [63:0] s0, s1, w_new, t1, t2;
	logic [383:0] new_val;

	assign inrange_in = ({28'd0, target_index} < 32'(mre_pkg::NUM_REGS));
	assign sel_in = target_index[mre_pkg::SEL_W-1:0];
	assign old_val = bank_q[sel_in];

	// Message schedule and round function.
	always_comb begin
		s0 = mre_pkg::rotr(w_q[1], 1) ^ mre_pkg::rotr(w_q[1], 8) ^ (w_q[1] >> 7);
		s1 = mre_pkg::rotr(w_q[14], 19) ^ mre_pkg::rotr(w_q[14], 61) ^ (w_q[14] >> 6);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		t1 = h_q + (mre_pkg::rotr(e_q, 14) ^ mre_pkg::rotr(e_q, 18) ^ mre_pkg::rotr(e_q, 41))
			+ ((e_q & f_q) ^ (~e_q & g_q)) + mre_pkg::ROUND_K[rnd_q] + w_q[0];
		t2 = (mre_pkg::rotr(a_q, 28) ^ mre_pkg::rotr(a_q, 34) ^ mre_pkg::rotr(a_q, 39))
			+ ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
		new_val = {mre_pkg::INIT_H[0] + a_q, mre_pkg::INIT_H[1] + b_q,
			mre_pkg::INIT_H[2] + c_q, mre_pkg::INIT_H[3] + d_q,
			mre_pkg::INIT_H[4] + e_q, mre_pkg::INIT_H[5] + f_q};
	end

	assign sts.do_hash = hash_q;
	assign sts.last_round = (rnd_q == mre_pkg::RND_W'(mre_pkg::ROUNDS - 1));

	// Measurement bank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mre_pkg::NUM_REGS; i++) bank_q[i] <= '0;
		end else if (cmd.finish) begin
			bank_q[sel_q] <= new_val;
		end
	end

	// Control flags of the item in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= 1'b0;
			inrange_q <= 1'b0;
			rnd_q <= '0;
		end else if (cmd.load) begin
			hash_q <= inrange_in && (digest_len == mre_pkg::DIGEST_BYTES);
			inrange_q <= inrange_in;
			rnd_q <= '0;
		end else if (cmd.round) begin
			rnd_q <= rnd_q + mre_pkg::RND_W'(1);
		end
	end

	// Working variables and schedule window.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= target_index;
			sel_q <= sel_in;
			for (int i = 0; i < 6; i++) w_q[i] <= old_val[383-64*i -: 64];
			w_q[6] <= digest_w0;
			w_q[7] <= digest_w1;
			w_q[8] <= digest_w2;
			w_q[9] <= digest_w3;
			w_q[10] <= digest_w4;
			w_q[11] <= digest_w5;
			w_q[12] <= 64'h8000000000000000;
			w_q[13] <= '0;
			w_q[14] <= '0;
			w_q[15] <= 64'd768;
			a_q <= mre_pkg::INIT_H[0];
			b_q <= mre_pkg::INIT_H[1];
			c_q <= mre_pkg::INIT_H[2];
			d_q <= mre_pkg::INIT_H[3];
			e_q <= mre_pkg::INIT_H[4];
			f_q <= mre_pkg::INIT_H[5];
			g_q <= mre_pkg::INIT_H[6];
			h_q <= mre_pkg::INIT_H[7];
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			h_q <= g_q;
			g_q <= f_q;
			f_q <= e_q;
			e_q <= d_q + t1;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= a_q;
			a_q <= t1 + t2;
		end
	end

	// Result fields: values read straight from the bank (zero out of range), status and index from the item's registers.
	always_comb begin
		status = hash_q ? mre_pkg::ST_EXTENDED : mre_pkg::ST_SKIPPED;
		out_index = idx_q;
		{value_w0, value_w1, value_w2, value_w3, value_w4, value_w5} =
			inrange_q ? bank_q[sel_q] : '0;
	end

	`MRE_ASSERT_SAME(a_hash_rng, clk, arst_n, hash_q, inrange_q)
	`MRE_ASSERT_NEXT(a_rnd_clr, clk, arst_n, cmd.load, rnd_q == '0)
	`MRE_ASSERT_SAME(a_rnd_only, clk, arst_n, cmd.round, hash_q)

endmodule

### dv/measurement_register_extend_test.sv
`timescale 1ns / 1ps
module measurement_register_extend_test;

	typedef logic [63:0] word_t;
	typedef word_t block6_t [6];

	// One request toward the register bank.
	typedef struct {
		logic [3:0] idx;
		logic [6:0] len;
		block6_t    dig;
		bit         hold;
	} extend_req_t;

	// One result that the bank should return.
	typedef struct {
		logic       st;
		logic [3:0] idx;
		block6_t    val;
	} extend_resp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [3:0]  target_index = '0;
	logic [6:0]  digest_len = '0;
	logic [63:0] digest_w0 = '0, digest_w1 = '0, digest_w2 = '0;
	logic [63:0] digest_w3 = '0, digest_w4 = '0, digest_w5 = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        status;
	logic [3:0]  out_index;
	logic [63:0] value_w0, value_w1, value_w2, value_w3, value_w4, value_w5;

	extend_req_t  req_queue[$];
	extend_resp_t resp_queue[$];
	block6_t      bank_model [mre_pkg::NUM_REGS];
	extend_req_t  cur_req;
	int           send_gap = 0;
	int           recv_gap = 0;
	int           fail_count = 0;

	measurement_register_extend dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Mostly short gaps, a good share of none, and now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(3);
		if (r < 97) return $urandom_range(12, 4);
		return $urandom_range(80, 20);
	endfunction

	function automatic word_t ror64(word_t x, int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	// One SHA-384 compression of the 96-byte message old value || digest.
	function automatic block6_t sha384_chain(block6_t prev, block6_t dig);
		word_t   w [80];
		word_t   v [8];
		word_t   t1, t2, s0, s1;
		block6_t res;
		for (int i = 0; i < 6; i++) begin
			w[i] = prev[i];
			w[6 + i] = dig[i];
		end
		w[12] = 64'h8000000000000000;
		w[13] = '0;
		w[14] = '0;
		w[15] = 64'd768;
		for (int i = 16; i < 80; i++) begin
			s0 = ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7);
			s1 = ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++) v[i] = mre_pkg::INIT_H[i];
		for (int i = 0; i < 80; i++) begin
			t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + mre_pkg::ROUND_K[i] + w[i];
			t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 6; i++) res[i] = mre_pkg::INIT_H[i] + v[i];
		return res;
	endfunction

	// Apply one accepted item to the register model and queue its result.
	function automatic void predict_extend(extend_req_t rq);
		extend_resp_t rs;
		rs.idx = rq.idx;
		if (rq.idx >= mre_pkg::NUM_REGS) begin
			rs.st = mre_pkg::ST_SKIPPED;
			for (int i = 0; i < 6; i++) rs.val[i] = '0;
		end else begin
			if (rq.len == mre_pkg::DIGEST_BYTES) begin
				bank_model[rq.idx[mre_pkg::SEL_W-1:0]] =
					sha384_chain(bank_model[rq.idx[mre_pkg::SEL_W-1:0]], rq.dig);
				rs.st = mre_pkg::ST_EXTENDED;
			end else begin
				rs.st = mre_pkg::ST_SKIPPED;
			end
			rs.val = bank_model[rq.idx[mre_pkg::SEL_W-1:0]];
		end
		resp_queue.insert(resp_queue.size(), rs);
	endfunction

	// Append one item to the pending stimulus.
	function automatic void enqueue_req(extend_req_t rq);
		req_queue.insert(req_queue.size(), rq);
	endfunction

	function automatic extend_req_t make_req(logic [3:0] idx, logic [6:0] len, word_t fill);
		extend_req_t rq;
		rq.idx = idx;
		rq.len = len;
		rq.hold = 1'b0;
		for (int i = 0; i < 6; i++) rq.dig[i] = fill;
		return rq;
	endfunction

	// Driver: present queued items, pausing between them at random.
	always @(posedge clk) begin
		bit busy;
		if (arst_n) begin
			busy = in_valid;
			if (in_valid && in_ready) begin
				predict_extend(cur_req);
				busy = 1'b0;
			end
			if (!busy) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (req_queue.size() > 0 &&
						!(req_queue[0].hold && resp_queue.size() > 0)) begin
					cur_req = req_queue.pop_front();
					target_index <= cur_req.idx;
					digest_len <= cur_req.len;
					digest_w0 <= cur_req.dig[0];
					digest_w1 <= cur_req.dig[1];
					digest_w2 <= cur_req.dig[2];
					digest_w3 <= cur_req.dig[3];
					digest_w4 <= cur_req.dig[4];
					digest_w5 <= cur_req.dig[5];
					busy = 1'b1;
					send_gap = pick_gap();
				end
			end
			in_valid <= busy;
		end
	end

	// Monitor: stall the result side at random and check each taken item.
	always @(posedge clk) begin
		extend_resp_t ex;
		word_t        got [6];
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{value_w0, value_w1, value_w2, value_w3, value_w4, value_w5};
				if (resp_queue.size() == 0) begin
					$error("result with nothing expected, index %0d", out_index);
					fail_count++;
				end else begin
					ex = resp_queue.pop_front();
					if (status !== ex.st) begin
						$error("status: expected %0d, got %0d", ex.st, status);
						fail_count++;
					end
					if (out_index !== ex.idx) begin
						$error("out_index: expected %0d, got %0d", ex.idx, out_index);
						fail_count++;
					end
					for (int i = 0; i < 6; i++) begin
						if (got[i] !== ex.val[i]) begin
							$error("value_w%0d: expected %h, got %h", i, ex.val[i], got[i]);
							fail_count++;
						end
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				recv_gap = pick_gap();
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		extend_req_t rq;
		int          r;
		for (int i = 0; i < mre_pkg::NUM_REGS; i++)
			for (int j = 0; j < 6; j++) bank_model[i][j] = '0;

		// Directed: every index, the length edges, all-zero and all-one digests.
		for (int i = 0; i < 16; i++)
			enqueue_req(make_req(4'(i), mre_pkg::DIGEST_BYTES, {64{i[0]}}));
		enqueue_req(make_req(4'd0, 7'd0, '1));
		enqueue_req(make_req(4'd1, 7'd47, '1));
		enqueue_req(make_req(4'd2, 7'd49, '0));
		enqueue_req(make_req(4'd3, 7'd64, '1));
		enqueue_req(make_req(4'd3, 7'd127, '1));
		enqueue_req(make_req(4'd15, 7'd127, '1));
		rq = make_req(4'd0, mre_pkg::DIGEST_BYTES, 64'h0123456789abcdef);
		rq.hold = 1'b1;
		enqueue_req(rq);

		// Random: mostly good extends into the real registers, the rest noise.
		for (int n = 0; n < 2000; n++) begin
			r = $urandom_range(99);
			rq.idx = (r < 85) ? 4'($urandom_range(mre_pkg::NUM_REGS - 1))
				: 4'($urandom_range(15));
			r = $urandom_range(99);
			rq.len = (r < 80) ? mre_pkg::DIGEST_BYTES : 7'($urandom_range(127));
			for (int i = 0; i < 6; i++) rq.dig[i] = {$urandom, $urandom};
			rq.hold = ($urandom_range(199) == 0);
			enqueue_req(rq);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (req_queue.size() > 0 || in_valid || resp_queue.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("** measurement_register_extend: PASSED **");
		else
			$display("** measurement_register_extend: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** measurement_register_extend: FAILED **");
		$finish;
	end

endmodule
